FILE: hdl/pfa_pkg.sv
package pfa_pkg;

  // Defaults for the top-level parameters. The page size is a power of two.
  localparam int unsigned MAX_FRAMES_DEF = 1024;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // The free map is held as words of this many frames each.
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;

  // Field widths fixed by the register and item formats.
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FRAME  = 2'd1,
    ST_NOT_HELD  = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT = 2'd0,
    CFG_BASE        = 2'd1,
    CFG_RESERVED    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]  frame_count;
    logic [ADDR_W-1:0] base;
    logic [CNT_W-1:0]  reserved;
  } cfg_t;

  // Number of map words needed for a given frame capacity.
  function automatic int unsigned map_words(int unsigned max_frames);
    return (max_frames + WORD_BITS - 1) / WORD_BITS;
  endfunction

  // Address width of the map memory.
  function automatic int unsigned map_aw(int unsigned max_frames);
    return (map_words(max_frames) > 1) ? $clog2(map_words(max_frames)) : 1;
  endfunction

endpackage

FILE: hdl/pfa_map_ram.sv
module pfa_map_ram #(
  parameter int unsigned MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
  localparam int unsigned AW = pfa_pkg::map_aw(MAX_FRAMES)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [pfa_pkg::WORD_BITS-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [pfa_pkg::WORD_BITS-1:0] rdata_o
);
  import pfa_pkg::*;

  localparam int unsigned NW = map_words(MAX_FRAMES);

  // One bit per frame, 1 meaning free. Contents are undefined until the
  // first initialise sweep writes every word.
  logic [WORD_BITS-1:0] mem_q [NW];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pfa_ctrl.sv
module pfa_ctrl #(
  parameter int unsigned MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BYTES = pfa_pkg::PAGE_BYTES_DEF,
  localparam int unsigned AW = pfa_pkg::map_aw(MAX_FRAMES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfa_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfa_pkg::OP_W-1:0]      operation_i,
  input  logic [pfa_pkg::ADDR_W-1:0]    free_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pfa_pkg::ADDR_W-1:0]    frame_address_o,
  output logic [pfa_pkg::STAT_W-1:0]    status_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [pfa_pkg::WORD_BITS-1:0] mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [pfa_pkg::WORD_BITS-1:0] mem_rdata_i
);
  import pfa_pkg::*;

  localparam int unsigned NW         = map_words(MAX_FRAMES);
  localparam int unsigned CW         = (AW + 1 > CNT_W + 1) ? AW + 1 : CNT_W + 1;
  localparam int unsigned CNT_MAX    = (1 << CNT_W) - 1;
  localparam int unsigned CAP        = (MAX_FRAMES > CNT_MAX) ? CNT_MAX : MAX_FRAMES;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INIT     = 6'b000010,
    S_ALLOC    = 6'b000100,
    S_FREE_RD  = 6'b001000,
    S_FREE_CHK = 6'b010000,
    S_RESP     = 6'b100000
  } state_e;

  // Free bits of word w when frames below lim are the ones that count.
  function automatic logic [WORD_BITS-1:0] word_mask(logic [CW-1:0] w,
                                                     logic [CNT_W-1:0] lim);
    logic [CW-1:0]        lw;
    logic [WORD_BITS-1:0] m;
    lw = CW'(lim >> BIT_W);
    m  = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = (BIT_W'(b) < lim[BIT_W-1:0]);
    end
    if (w < lw) begin
      m = '1;
    end else if (w != lw) begin
      m = '0;
    end
    return m;
  endfunction

  // Position of the lowest set bit.
  function automatic logic [BIT_W-1:0] first_one(logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (v[b]) begin
        p = BIT_W'(b);
      end
    end
    return p;
  endfunction

  state_e               state_q, state_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [CW-1:0]        chk_ptr_q, chk_ptr_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  status_e              stat_q, stat_d;
  logic                 grant_q, grant_d;
  logic                 ready_q, ready_d;
  logic                 out_valid_q;
  logic [ADDR_W-1:0]    out_addr_q;
  status_e              out_stat_q;

  logic [CNT_W-1:0]     n_frames;
  logic [CNT_W-1:0]     res_frames;
  logic [CNT_W-1:0]     free_lim;
  logic [CNT_W:0]       words_sum;
  logic [CW-1:0]        words_used;
  logic [ADDR_W-1:0]    fr_delta;
  logic [ADDR_W-1:0]    fr_index;
  logic                 fr_hit;
  logic [CW-1:0]        fr_word;
  logic [WORD_BITS-1:0] masked;
  logic [BIT_W-1:0]     hit_bit;
  logic [CW+BIT_W-1:0]  hit_idx;
  logic                 load_out;

  // Managed count saturates at the map capacity; the reserve never exceeds it.
  assign n_frames   = (cfg_i.frame_count > CNT_W'(CAP)) ? CNT_W'(CAP) : cfg_i.frame_count;
  assign res_frames = (cfg_i.reserved > n_frames) ? n_frames : cfg_i.reserved;
  assign free_lim   = n_frames - res_frames;
  assign words_sum  = {1'b0, n_frames} + (CNT_W + 1)'(WORD_BITS - 1);
  assign words_used = CW'(words_sum >> BIT_W);

  // Frame addresses may wrap through zero, but the managed range spans far
  // less than the whole address space, so an address maps back to at most one
  // frame index.
  assign fr_delta = free_address_i - cfg_i.base;
  assign fr_index = fr_delta >> PAGE_SHIFT;
  assign fr_hit   = (fr_delta[PAGE_SHIFT-1:0] == '0) && (fr_index < ADDR_W'(n_frames));
  assign fr_word  = CW'(idx_q >> BIT_W);

  assign masked  = mem_rdata_i & word_mask(chk_ptr_q, n_frames);
  assign hit_bit = first_one(masked);
  assign hit_idx = {chk_ptr_q, hit_bit};

  assign in_ready_o = (state_q == S_IDLE);
  assign load_out   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    chk_vld_d   = 1'b0;
    chk_ptr_d   = chk_ptr_q;
    idx_d       = idx_q;
    stat_d      = stat_q;
    grant_d     = grant_q;
    ready_d     = ready_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q[AW-1:0];
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          grant_d = 1'b0;
          ptr_d   = '0;
          case (op_e'(operation_i))
            OP_INIT: begin
              state_d = S_INIT;
            end
            OP_ALLOC: begin
              if (!ready_q) begin
                stat_d  = ST_NOT_READY;
                state_d = S_RESP;
              end else begin
                stat_d  = ST_NO_FRAME;
                state_d = S_ALLOC;
              end
            end
            OP_FREE: begin
              if (!ready_q) begin
                stat_d  = ST_NOT_READY;
                state_d = S_RESP;
              end else if (fr_hit) begin
                idx_d   = fr_index[CNT_W-1:0];
                state_d = S_FREE_RD;
              end else begin
                stat_d  = ST_NOT_HELD;
                state_d = S_RESP;
              end
            end
            default: begin
              stat_d  = ST_DONE;
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_INIT: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = word_mask(ptr_q, free_lim);
        ptr_d       = ptr_q + 1'b1;
        if (ptr_q == CW'(NW - 1)) begin
          ready_d = 1'b1;
          stat_d  = ST_DONE;
          state_d = S_RESP;
        end
      end

      S_ALLOC: begin
        if (chk_vld_q && (masked != '0)) begin
          mem_we_o             = 1'b1;
          mem_waddr_o          = chk_ptr_q[AW-1:0];
          mem_wdata_o          = mem_rdata_i;
          mem_wdata_o[hit_bit] = 1'b0;
          idx_d                = hit_idx[CNT_W-1:0];
          grant_d              = 1'b1;
          stat_d               = ST_DONE;
          state_d              = S_RESP;
        end else if (ptr_q < words_used) begin
          mem_re_o  = 1'b1;
          ptr_d     = ptr_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_ptr_d = ptr_q;
        end else if (!chk_vld_q) begin
          state_d = S_RESP;
        end
      end

      S_FREE_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = fr_word[AW-1:0];
        state_d     = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        if (!mem_rdata_i[idx_q[BIT_W-1:0]]) begin
          mem_we_o                         = 1'b1;
          mem_waddr_o                      = fr_word[AW-1:0];
          mem_wdata_o                      = mem_rdata_i;
          mem_wdata_o[idx_q[BIT_W-1:0]]    = 1'b1;
          stat_d                           = ST_DONE;
        end else begin
          stat_d = ST_NOT_HELD;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ready_q   <= ready_d;
      chk_vld_q <= chk_vld_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    chk_ptr_q <= chk_ptr_d;
    idx_q     <= idx_d;
    stat_q    <= stat_d;
    grant_q   <= grant_d;
    if (load_out) begin
      out_addr_q <= grant_q ? (cfg_i.base + (ADDR_W'(idx_q) << PAGE_SHIFT)) : '0;
      out_stat_q <= stat_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_address_o = out_addr_q;
  assign status_o        = out_stat_q;

endmodule

FILE: hdl/page_frame_allocator.sv
// First-fit physical page frame allocator over a bitmap held in block memory.
//
// Configuration: a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i) sets
// the frame count, the address of frame zero and the number of reserved frames
// at the top of the range. Write it only while the block is idle.
// Input channel (in_valid_i/in_ready_o) carries one item: an operation and, for
// a free, the frame address. Output channel (out_valid_o/out_ready_i) returns
// one item per input: the allocated address (zero otherwise) and a status.
// Initialise writes every 32-frame map word. Allocate reads at most
// ceil(n / 32) map words, n being the frame count saturated at the map
// capacity, one map word per cycle through the single memory read port.
// A free of a managed frame reads its map word and, if the frame is held,
// writes it back. One item is processed at a time.
// The output register holds a finished result, so the next item is accepted
// while it waits; if the receiver stalls, that next item finishes and then
// waits for the output register to empty.
// Reset clears the configuration and marks the map not initialised; the map
// memory itself is not cleared, because initialise rewrites every word.
module page_frame_allocator #(
  parameter int unsigned MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BYTES = pfa_pkg::PAGE_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pfa_pkg::ADDR_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pfa_pkg::OP_W-1:0]         operation_i,
  input  logic [pfa_pkg::ADDR_W-1:0]       free_address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pfa_pkg::ADDR_W-1:0]       frame_address_o,
  output logic [pfa_pkg::STAT_W-1:0]       status_o
);
  import pfa_pkg::*;

  localparam int unsigned AW = map_aw(MAX_FRAMES);

  // Configuration registers. The controller reads them live, so a change of
  // count or base after initialise takes effect on the next item.
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_COUNT: cfg_d.frame_count = cfg_wdata_i[CNT_W-1:0];
        CFG_BASE:        cfg_d.base        = cfg_wdata_i;
        CFG_RESERVED:    cfg_d.reserved    = cfg_wdata_i[CNT_W-1:0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // The controller does the read-modify-write on the map. Only one item is in
  // flight and each write lands before the next read is issued, so no
  // forwarding path is needed.
  pfa_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .free_address_i  (free_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_address_o (frame_address_o),
    .status_o        (status_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  pfa_map_ram #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: hdl/pfa_checker.sv
module pfa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [pfa_pkg::ADDR_W-1:0]    frame_address_o,
  input logic [pfa_pkg::STAT_W-1:0]    status_o
);
  import pfa_pkg::*;

  // A non-zero address only ever comes with a successful allocation.
  a_addr_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_address_o != '0) |-> status_o == ST_DONE)
    else $error("non-zero frame address with a failure status");

  // Items are handled one at a time: acceptance closes the input side.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is still being processed");

  // A new result only appears after an item has been worked on.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised without an item in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(frame_address_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);
